// File: rtl/hvf_pkg.sv
// ============================================================================
// hvf_pkg - shared types and constants of the HAR volatility forecast
// Field widths, configuration register indexes and the coefficient bundle.
// ============================================================================
package hvf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int FC_W       = 32;
    localparam int MEAN_W     = 25;
    localparam int RECIP_W    = 32;
    localparam int ACC_W      = 61;
    localparam int FRAC_SHIFT = 20;
    localparam int IN_TDATA_W = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_INTERCEPT = 3'd0,
        CFG_COEF_DAILY     = 3'd1,
        CFG_COEF_WEEKLY    = 3'd2,
        CFG_COEF_MONTHLY   = 3'd3,
        CFG_COEF_JUMP      = 3'd4,
        CFG_MODEL_FITTED   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] intercept;
        logic signed [COEF_W-1:0] daily;
        logic signed [COEF_W-1:0] weekly;
        logic signed [COEF_W-1:0] monthly;
        logic signed [COEF_W-1:0] jump;
    } coef_t;

endpackage

// File: rtl/hvf_forecast_pipe.sv
// ============================================================================
// hvf_forecast_pipe - four-stage forecast datapath
// Lag means by reciprocal multiply, coefficient products, partial sums, then
// rounding, saturation and the not-ready zeroing into the result register.
// ============================================================================
module hvf_forecast_pipe #(
    parameter int WEEK_LAGS  = 5,
    parameter int MONTH_LAGS = 22
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hvf_pkg::SAMPLE_W-1:0]         in_rv,
    input  logic [hvf_pkg::SAMPLE_W-1:0]         in_jv,
    input  logic [hvf_pkg::SAMPLE_W+$clog2(WEEK_LAGS)-1:0]  in_wsum,
    input  logic [hvf_pkg::SAMPLE_W+$clog2(MONTH_LAGS)-1:0] in_msum,
    input  logic                                 in_live,
    input  hvf_pkg::coef_t                       coef,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hvf_pkg::FC_W-1:0]             out_forecast,
    output logic                                 out_live
);

    localparam int WSUM_W = hvf_pkg::SAMPLE_W + $clog2(WEEK_LAGS);
    localparam int MSUM_W = hvf_pkg::SAMPLE_W + $clog2(MONTH_LAGS);
    localparam int SW     = hvf_pkg::SAMPLE_W;
    localparam int CW     = hvf_pkg::COEF_W;
    localparam int MW     = hvf_pkg::MEAN_W;
    localparam int AW     = hvf_pkg::ACC_W;
    localparam int FW     = hvf_pkg::FC_W;
    localparam int SH     = hvf_pkg::FRAC_SHIFT;
    localparam int RW     = hvf_pkg::RECIP_W;
    localparam int PS_W   = CW + SW + 1;
    localparam int PM_W   = CW + MW + 1;
    localparam int PI_W   = CW + SH;
    localparam int QW     = AW - SH;

    localparam logic [RW-1:0] RECIP_WEEK  = RW'((((64'd1 << 33) / WEEK_LAGS) + 64'd1) >> 1);
    localparam logic [RW-1:0] RECIP_MONTH = RW'((((64'd1 << 33) / MONTH_LAGS) + 64'd1) >> 1);
    localparam logic [WSUM_W+RW:0] HALF_W = (WSUM_W+RW+1)'(64'd1 << (RW - 1));
    localparam logic [MSUM_W+RW:0] HALF_M = (MSUM_W+RW+1)'(64'd1 << (RW - 1));
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(64'd1 << (SH - 1));
    localparam logic [FW-1:0] FC_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0] FC_MIN = {1'b1, {(FW-1){1'b0}}};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: lag means
    logic [WSUM_W+RW-1:0] wprod;
    logic [MSUM_W+RW-1:0] mprod;
    logic [WSUM_W+RW:0]   wrnd;
    logic [MSUM_W+RW:0]   mrnd;
    logic [SW-1:0]        rv1_reg, jv1_reg;
    logic [MW-1:0]        mw1_reg, mm1_reg;
    logic                 live1_reg;

    // stage 2: products
    logic signed [PI_W-1:0] pi2_reg;
    logic signed [PS_W-1:0] pd2_reg, pj2_reg;
    logic signed [PM_W-1:0] pw2_reg, pm2_reg;
    logic                   live2_reg;

    // stage 3: partial sums
    logic signed [AW-1:0] sa3_reg, sb3_reg;
    logic                 live3_reg;

    // stage 4: result
    logic signed [AW-1:0] acc;
    logic signed [QW-1:0] quo;
    logic [QW-FW:0]       quo_hi;
    logic [FW-1:0]        fc_sat;
    logic [FW-1:0]        fc4_reg;
    logic                 live4_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign wprod = in_wsum * RECIP_WEEK;
    assign mprod = in_msum * RECIP_MONTH;
    assign wrnd  = {1'b0, wprod} + HALF_W;
    assign mrnd  = {1'b0, mprod} + HALF_M;

    assign acc    = sa3_reg + sb3_reg + ROUND_HALF;
    assign quo    = acc[AW-1:SH];
    assign quo_hi = quo[QW-1:FW-1];

    always_comb begin
        if ((&quo_hi) || !(|quo_hi)) begin
            fc_sat = quo[FW-1:0];
        end else if (quo[QW-1]) begin
            fc_sat = FC_MIN;
        end else begin
            fc_sat = FC_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            rv1_reg   <= in_rv;
            jv1_reg   <= in_jv;
            mw1_reg   <= wrnd[RW +: MW];
            mm1_reg   <= mrnd[RW +: MW];
            live1_reg <= in_live;
        end
        if (rdy2) begin
            pi2_reg   <= {coef.intercept, {SH{1'b0}}};
            pd2_reg   <= coef.daily * $signed({1'b0, rv1_reg});
            pj2_reg   <= coef.jump * $signed({1'b0, jv1_reg});
            pw2_reg   <= coef.weekly * $signed({1'b0, mw1_reg});
            pm2_reg   <= coef.monthly * $signed({1'b0, mm1_reg});
            live2_reg <= live1_reg;
        end
        if (rdy3) begin
            sa3_reg   <= AW'(pi2_reg) + AW'(pd2_reg) + AW'(pj2_reg);
            sb3_reg   <= AW'(pw2_reg) + AW'(pm2_reg);
            live3_reg <= live2_reg;
        end
        if (rdy4) begin
            fc4_reg   <= live3_reg ? fc_sat : '0;
            live4_reg <= live3_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign out_forecast = fc4_reg;
    assign out_live     = live4_reg;

endmodule

// File: rtl/har_volatility_forecast.sv
// ============================================================================
// har_volatility_forecast - next-day variance forecast with jump term
// Keeps the sample history and running lag sums, feeds the forecast pipeline.
//
//   channel   dir  handshake              payload
//   s_*       in   s_tvalid / s_tready    s_tdata: rv_sample, jump_sample
//   m_*       out  m_tvalid / m_tready    m_tdata: forecast; m_tuser: ready_res
//   cfg_*     in   cfg_wr_en              cfg_index, cfg_wdata
//
// One transfer per cycle while the result side accepts results; m_tvalid rises
// once the transfer has passed the input register, then the mean, product,
// sum and result stages.
// Each stage holds while the stage after it is full and stalled, so a stall
// on m_tready backs up into s_tready only once every stage is occupied.
// Synchronous reset clears history, lag sums, sample count and coefficients.
// ============================================================================
module har_volatility_forecast #(
    parameter int WEEK_LAGS  = 5,
    parameter int MONTH_LAGS = 22
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hvf_pkg::IN_TDATA_W-1:0]    s_tdata,   // rv_sample, jump_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hvf_pkg::FC_W-1:0]          m_tdata,   // forecast
    output logic [0:0]                        m_tuser,   // ready_res
    input  logic                              cfg_wr_en,
    input  logic [hvf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hvf_pkg::COEF_W-1:0]        cfg_wdata
);

    localparam int SW         = hvf_pkg::SAMPLE_W;
    localparam int HIST_DEPTH = (WEEK_LAGS > MONTH_LAGS) ? WEEK_LAGS : MONTH_LAGS;
    localparam int WSUM_W     = SW + $clog2(WEEK_LAGS);
    localparam int MSUM_W     = SW + $clog2(MONTH_LAGS);
    localparam int SEEN_W     = $clog2(HIST_DEPTH + 2);
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(HIST_DEPTH + 1);

    logic [SW-1:0]     hist_reg [HIST_DEPTH];
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [MSUM_W-1:0] msum_reg, msum_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    hvf_pkg::coef_t    coef_reg;
    logic              fitted_reg;

    logic              a_valid_reg;
    logic [SW-1:0]     a_rv_reg, a_jv_reg;
    logic [WSUM_W-1:0] a_wsum_reg;
    logic [MSUM_W-1:0] a_msum_reg;
    logic              a_live_reg;

    logic [SW-1:0]     rv_in, jv_in;
    logic              s_xfer;
    logic              dp_ready;

    assign rv_in    = s_tdata[SW-1:0];
    assign jv_in    = s_tdata[2*SW-1:SW];
    assign s_tready = !a_valid_reg || dp_ready;
    assign s_xfer   = s_tvalid && s_tready;

    assign wsum_next = wsum_reg + WSUM_W'(rv_in) - WSUM_W'(hist_reg[WEEK_LAGS-1]);
    assign msum_next = msum_reg + MSUM_W'(rv_in) - MSUM_W'(hist_reg[MONTH_LAGS-1]);
    assign seen_next = (seen_reg < SEEN_FULL) ? seen_reg + SEEN_W'(1) : seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            wsum_reg    <= '0;
            msum_reg    <= '0;
            seen_reg    <= '0;
            coef_reg    <= '0;
            fitted_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (s_xfer) begin
                for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= rv_in;
                wsum_reg    <= wsum_next;
                msum_reg    <= msum_next;
                seen_reg    <= seen_next;
            end
            if (cfg_wr_en) begin
                case (hvf_pkg::cfg_index_t'(cfg_index))
                    hvf_pkg::CFG_COEF_INTERCEPT: coef_reg.intercept <= cfg_wdata;
                    hvf_pkg::CFG_COEF_DAILY:     coef_reg.daily     <= cfg_wdata;
                    hvf_pkg::CFG_COEF_WEEKLY:    coef_reg.weekly    <= cfg_wdata;
                    hvf_pkg::CFG_COEF_MONTHLY:   coef_reg.monthly   <= cfg_wdata;
                    hvf_pkg::CFG_COEF_JUMP:      coef_reg.jump      <= cfg_wdata;
                    hvf_pkg::CFG_MODEL_FITTED:   fitted_reg         <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // capture the item with the lag sums as they stood before it
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_rv_reg   <= rv_in;
            a_jv_reg   <= jv_in;
            a_wsum_reg <= wsum_reg;
            a_msum_reg <= msum_reg;
            a_live_reg <= fitted_reg && (seen_next == SEEN_FULL);
        end
    end

    hvf_forecast_pipe #(
        .WEEK_LAGS    (WEEK_LAGS),
        .MONTH_LAGS   (MONTH_LAGS)
    ) u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (a_valid_reg),
        .in_ready     (dp_ready),
        .in_rv        (a_rv_reg),
        .in_jv        (a_jv_reg),
        .in_wsum      (a_wsum_reg),
        .in_msum      (a_msum_reg),
        .in_live      (a_live_reg),
        .coef         (coef_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_forecast (m_tdata),
        .out_live     (m_tuser[0])
    );

endmodule

// File: rtl/hvf_checker.sv
// ============================================================================
// hvf_checker - port-level checks of the HAR volatility forecast
// Reset behavior, not-ready zeroing, input open when drained and stalled result hold.
// ============================================================================
module hvf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hvf_pkg::FC_W-1:0]       m_tdata,
    input logic [0:0]                     m_tuser
);

    // reset empties every stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // a result without enough history or fit carries a zero forecast
    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero forecast on a not-ready result");

    // input side stays open while the result slot is free
    a_open_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result slot");

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind har_volatility_forecast hvf_checker u_hvf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: sim/har_volatility_forecast_test.sv
// ============================================================================
// har_volatility_forecast_test - self-checking bench for the HAR forecast
// Walks a table of directed transfers: the edges of the sample fields, the
// first ready forecast, saturation at both ends, the unfitted model, a write
// to an unused register index and both halves of the rounding step. It then
// runs random phases that each reprogram the coefficients while the block is
// idle. Random idling runs on both channels, with one phase of no idling and
// one long stall on the result side. Every forecast is checked field by field
// against its table entry or, in the random phases, against an in-bench
// forecast model that tracks the sample history and the lag sums.
// ============================================================================
module har_volatility_forecast_test;

    localparam int WEEK_LAGS     = 5;
    localparam int MONTH_LAGS    = 22;
    localparam int HIST_DEPTH    = (WEEK_LAGS > MONTH_LAGS) ? WEEK_LAGS : MONTH_LAGS;
    localparam logic [63:0] RECIP_WEEK  = ((64'd1 << 33) / 64'(WEEK_LAGS) + 64'd1) >> 1;
    localparam logic [63:0] RECIP_MONTH = ((64'd1 << 33) / 64'(MONTH_LAGS) + 64'd1) >> 1;
    localparam longint FC_MAX    = longint'(32'sh7FFF_FFFF);
    localparam longint FC_MIN    = longint'(32'sh8000_0000);
    localparam logic [hvf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
    localparam int TOTAL_SAMPLES = 1450;
    localparam int HOLD_CYCLES   = 60;
    localparam int IDLE_PCT      = 32;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [hvf_pkg::FC_W-1:0] value;
        logic                     ready;
    } forecast_t;

    typedef enum bit {ROW_CFG, ROW_SAMPLE} row_kind_t;
    typedef enum int {SET_ZERO, SET_EXTREME, SET_NEAR_UNITY, SET_WIDE} setting_t;

    typedef struct {
        row_kind_t                      kind;
        logic [hvf_pkg::CFG_IDX_W-1:0]  index;
        logic [hvf_pkg::COEF_W-1:0]     word;
        logic [hvf_pkg::SAMPLE_W-1:0]   rv;
        logic [hvf_pkg::SAMPLE_W-1:0]   jump;
        forecast_t                      want;
    } plan_row_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [hvf_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [hvf_pkg::FC_W-1:0]           m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_wr_en;
    logic [hvf_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [hvf_pkg::COEF_W-1:0]         cfg_wdata;

    // side information that travels with each input transfer
    bit                                 s_typed;
    forecast_t                          s_typed_want;

    // forecast model state
    hvf_pkg::coef_t                     weights;
    logic                               fitted;
    logic [hvf_pkg::SAMPLE_W-1:0]       rv_hist [HIST_DEPTH];
    int                                 hist_fill;
    logic [31:0]                        week_total;
    logic [31:0]                        month_total;

    forecast_t                          forecast_due [$];
    int                                 samples_sent;
    int                                 forecasts_seen;
    int                                 bad_forecasts;
    bit                                 steady;
    bit                                 hold_req;
    plan_row_t                          plan [$];

    har_volatility_forecast #(
        .WEEK_LAGS  (WEEK_LAGS),
        .MONTH_LAGS (MONTH_LAGS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic plan_row_t cfg_row(logic [hvf_pkg::CFG_IDX_W-1:0] index,
                                          logic [hvf_pkg::COEF_W-1:0] word);
        cfg_row = '{ROW_CFG, index, word, '0, '0, '0};
    endfunction

    function automatic plan_row_t sample_row(logic [hvf_pkg::SAMPLE_W-1:0] rv,
                                             logic [hvf_pkg::SAMPLE_W-1:0] jump,
                                             logic [hvf_pkg::FC_W-1:0] value, logic ready);
        sample_row = '{ROW_SAMPLE, '0, '0, rv, jump, '{value, ready}};
    endfunction

    task automatic har_forecast(input logic [hvf_pkg::SAMPLE_W-1:0] rv,
                                input logic [hvf_pkg::SAMPLE_W-1:0] jv,
                                output forecast_t f);
        logic [63:0] mean_w;
        logic [63:0] mean_m;
        longint      acc;
        longint      fc;
        mean_w = (64'(week_total) * RECIP_WEEK + 64'h8000_0000) >> 32;
        mean_m = (64'(month_total) * RECIP_MONTH + 64'h8000_0000) >> 32;
        if (hist_fill < HIST_DEPTH + 1) hist_fill++;
        f = '0;
        if (fitted && hist_fill >= HIST_DEPTH + 1) begin
            acc = longint'(weights.intercept) <<< hvf_pkg::FRAC_SHIFT;
            acc += longint'(weights.daily) * longint'(rv);
            acc += longint'(weights.weekly) * longint'(mean_w);
            acc += longint'(weights.monthly) * longint'(mean_m);
            acc += longint'(weights.jump) * longint'(jv);
            fc = (acc + (longint'(1) <<< (hvf_pkg::FRAC_SHIFT - 1))) >>> hvf_pkg::FRAC_SHIFT;
            if (fc > FC_MAX) begin
                fc = FC_MAX;
            end else if (fc < FC_MIN) begin
                fc = FC_MIN;
            end
            f.value = fc[hvf_pkg::FC_W-1:0];
            f.ready = 1'b1;
        end
        week_total  = week_total + rv - rv_hist[WEEK_LAGS-1];
        month_total = month_total + rv - rv_hist[MONTH_LAGS-1];
        for (int i = HIST_DEPTH - 1; i > 0; i--) rv_hist[i] = rv_hist[i-1];
        rv_hist[0] = rv;
    endtask

    task automatic send_sample(input logic [hvf_pkg::SAMPLE_W-1:0] rv,
                               input logic [hvf_pkg::SAMPLE_W-1:0] jv,
                               input bit typed, input forecast_t want);
        if (!steady && !hold_req) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= {jv, rv};
        s_typed      <= typed;
        s_typed_want <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (forecasts_seen != samples_sent) @(posedge aclk);
    endtask

    task automatic load_setting(input setting_t style, input bit spare);
        hvf_pkg::cfg_index_t        slots [5] = '{hvf_pkg::CFG_COEF_INTERCEPT,
                                                  hvf_pkg::CFG_COEF_DAILY,
                                                  hvf_pkg::CFG_COEF_WEEKLY,
                                                  hvf_pkg::CFG_COEF_MONTHLY,
                                                  hvf_pkg::CFG_COEF_JUMP};
        logic [hvf_pkg::COEF_W-1:0] word;
        drain();
        for (int k = 0; k < 5; k++) begin
            case (style)
                SET_ZERO: begin
                    word = '0;
                end
                SET_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0: word = 32'h7FFF_FFFF;
                        1: word = 32'h8000_0000;
                        2: word = 32'h0000_0000;
                        default: word = 32'hFFFF_FFFF;
                    endcase
                end
                SET_NEAR_UNITY: begin
                    word = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                end
                default: begin
                    word = $urandom();
                end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= slots[k];
            cfg_wdata <= word;
            @(posedge aclk);
        end
        word    = $urandom();
        word[0] = ($urandom_range(0, 99) < 85);
        cfg_index <= hvf_pkg::CFG_MODEL_FITTED;
        cfg_wdata <= word;
        @(posedge aclk);
        if (spare) begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= $urandom();
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("har_volatility_forecast regression: fail");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        forecast_t got;
        forecast_t want;
        if (!aresetn) begin
            weights     = '0;
            fitted      = 1'b0;
            hist_fill   = 0;
            week_total  = '0;
            month_total = '0;
            foreach (rv_hist[i]) rv_hist[i] = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hvf_pkg::CFG_COEF_INTERCEPT: weights.intercept = cfg_wdata;
                    hvf_pkg::CFG_COEF_DAILY:     weights.daily     = cfg_wdata;
                    hvf_pkg::CFG_COEF_WEEKLY:    weights.weekly    = cfg_wdata;
                    hvf_pkg::CFG_COEF_MONTHLY:   weights.monthly   = cfg_wdata;
                    hvf_pkg::CFG_COEF_JUMP:      weights.jump      = cfg_wdata;
                    hvf_pkg::CFG_MODEL_FITTED:   fitted            = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tuser[0]};
                if (forecast_due.size() == 0) begin
                    bad_forecasts++;
                    if (bad_forecasts <= MAX_REPORTS)
                        $display("unexpected forecast %h ready %b", got.value, got.ready);
                end else begin
                    want = forecast_due.pop_front();
                    if (got.value !== want.value || got.ready !== want.ready) begin
                        bad_forecasts++;
                        if (bad_forecasts <= MAX_REPORTS)
                            $display("forecast mismatch: expected %h ready %b, got %h ready %b",
                                     want.value, want.ready, got.value, got.ready);
                    end
                end
                forecasts_seen++;
            end
            if (s_tvalid && s_tready) begin
                har_forecast(s_tdata[hvf_pkg::SAMPLE_W-1:0],
                             s_tdata[2*hvf_pkg::SAMPLE_W-1:hvf_pkg::SAMPLE_W], want);
                if (s_typed) want = s_typed_want;
                forecast_due.push_back(want);
            end
        end
    end

    initial begin
        int                           phase;
        int                           span;
        int                           pick;
        bit                           cfg_open;
        logic [hvf_pkg::SAMPLE_W-1:0] rv;
        logic [hvf_pkg::SAMPLE_W-1:0] jv;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_typed      = 1'b0;
        s_typed_want = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        cfg_open     = 1'b0;

        plan = {
            cfg_row(hvf_pkg::CFG_MODEL_FITTED,   32'h0000_0001),
            cfg_row(hvf_pkg::CFG_COEF_INTERCEPT, 32'h7FFF_FFFF),
            cfg_row(hvf_pkg::CFG_COEF_DAILY,     32'h7FFF_FFFF),
            cfg_row(hvf_pkg::CFG_COEF_WEEKLY,    32'h7FFF_FFFF),
            cfg_row(hvf_pkg::CFG_COEF_MONTHLY,   32'h7FFF_FFFF),
            cfg_row(hvf_pkg::CFG_COEF_JUMP,      32'h7FFF_FFFF),
            sample_row(24'h000000, 24'h000000, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'h000000, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'h000000, '0, 1'b0),
            sample_row(24'hAAAAAA, 24'h555555, '0, 1'b0),
            sample_row(24'h555555, 24'hAAAAAA, '0, 1'b0),
            sample_row(24'h800000, 24'h000001, '0, 1'b0),
            sample_row(24'h000001, 24'h800000, '0, 1'b0),
            sample_row(24'h7FFFFF, 24'hFFFFFE, '0, 1'b0),
            sample_row(24'h123456, 24'h654321, '0, 1'b0),
            sample_row(24'hFEDCBA, 24'h012345, '0, 1'b0),
            sample_row(24'h0F0F0F, 24'hF0F0F0, '0, 1'b0),
            sample_row(24'hF0F0F0, 24'h0F0F0F, '0, 1'b0),
            sample_row(24'h100000, 24'h100000, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'h3C3C3C, 24'hC3C3C3, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'h000000, '0, 1'b0),
            sample_row(24'h000000, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'hDEADBE, 24'h00BEEF, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'h080000, 24'h7FFFFF, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'hFFFFFF, '0, 1'b0),
            sample_row(24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 1'b1),
            cfg_row(hvf_pkg::CFG_COEF_INTERCEPT, 32'h8000_0000),
            cfg_row(hvf_pkg::CFG_COEF_DAILY,     32'h8000_0000),
            cfg_row(hvf_pkg::CFG_COEF_WEEKLY,    32'h8000_0000),
            cfg_row(hvf_pkg::CFG_COEF_MONTHLY,   32'h8000_0000),
            cfg_row(hvf_pkg::CFG_COEF_JUMP,      32'h8000_0000),
            sample_row(24'hFFFFFF, 24'hFFFFFF, 32'h8000_0000, 1'b1),
            cfg_row(hvf_pkg::CFG_MODEL_FITTED,   32'hFFFF_FFFE),
            cfg_row(CFG_SPARE,                   32'hFFFF_FFFF),
            sample_row(24'h123456, 24'hABCDEF, '0, 1'b0),
            cfg_row(hvf_pkg::CFG_MODEL_FITTED,   32'h8000_0001),
            cfg_row(hvf_pkg::CFG_COEF_INTERCEPT, 32'h0000_0000),
            cfg_row(hvf_pkg::CFG_COEF_DAILY,     32'h0000_0001),
            cfg_row(hvf_pkg::CFG_COEF_WEEKLY,    32'h0000_0000),
            cfg_row(hvf_pkg::CFG_COEF_MONTHLY,   32'h0000_0000),
            cfg_row(hvf_pkg::CFG_COEF_JUMP,      32'h0000_0000),
            sample_row(24'h080000, 24'hFFFFFF, 32'h0000_0001, 1'b1),
            cfg_row(hvf_pkg::CFG_COEF_DAILY,     32'hFFFF_FFFF),
            sample_row(24'h080000, 24'hFFFFFF, 32'h0000_0000, 1'b1)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                if (!cfg_open) drain();
                cfg_wr_en <= 1'b1;
                cfg_index <= plan[r].index;
                cfg_wdata <= plan[r].word;
                @(posedge aclk);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_wr_en <= 1'b0;
                cfg_open = 1'b0;
                send_sample(plan[r].rv, plan[r].jump, 1'b1, plan[r].want);
            end
        end

        phase = 0;
        while (samples_sent < TOTAL_SAMPLES) begin
            load_setting((phase < 4) ? setting_t'(phase) : setting_t'($urandom_range(0, 3)),
                         $urandom_range(0, 3) == 0);
            steady = (phase == 1);
            if (phase == 2) hold_req = 1'b1;
            span = (phase == 1) ? 200 : $urandom_range(40, 160);
            for (int n = 0; n < span && samples_sent < TOTAL_SAMPLES; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    rv = $urandom();
                    jv = $urandom();
                end else if (pick < 8) begin
                    rv = $urandom_range(0, 24'h1F_FFFF);
                    jv = $urandom_range(0, 24'h1F_FFFF);
                end else begin
                    rv = (pick == 8) ? 24'h000000 : 24'hFFFFFF;
                    jv = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                end
                send_sample(rv, jv, 1'b0, '0);
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (bad_forecasts == 0 && forecast_due.size() == 0) begin
            $display("har_volatility_forecast regression: pass");
        end else begin
            $display("har_volatility_forecast regression: fail");
        end
        $finish;
    end

endmodule
